### rtl/plc_pkg.sv
// Shared types and constants for the presence light controller.
package plc_pkg;

  localparam int REQ_W     = 2;
  localparam int TIME_W    = 32;
  localparam int RADAR_W   = 2;
  localparam int MODE_W    = 2;
  localparam int MS_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  // Request codes carried in req_type.
  localparam logic [REQ_W-1:0] REQ_PROCESS    = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MANUAL_ON  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MANUAL_OFF = 2'd2;
  localparam logic [REQ_W-1:0] REQ_ARM        = 2'd3;

  // Operating modes. Only power saving disables presence switch-on and the link;
  // the spare code behaves like the other modes that are not power saving.
  localparam logic [MODE_W-1:0] MODE_OPTIMISE   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_NORMAL     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POWER_SAVE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SPARE      = 2'd3;

  // Configuration register indices.
  localparam logic [CFG_ADDR_W-1:0] CFG_OP_MODE     = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_HOLD_MS     = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_OVERRIDE_MS = 2'd2;

  // Register values after reset.
  localparam logic [MODE_W-1:0] OP_MODE_RESET     = MODE_NORMAL;
  localparam logic [MS_W-1:0]   HOLD_MS_RESET     = 16'd5000;
  localparam logic [MS_W-1:0]   OVERRIDE_MS_RESET = 16'd30000;

  typedef struct packed {
    logic [MODE_W-1:0] op_mode;
    logic [MS_W-1:0]   hold_ms;
    logic [MS_W-1:0]   override_ms;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [TIME_W-1:0]  now_ms;
    logic [RADAR_W-1:0] radar_state;
    logic               alarm_match;
  } item_t;

  typedef struct packed {
    logic lamp_on;
    logic link_enable;
  } result_t;

endpackage

### rtl/plc_cfg_regs.sv
// Configuration register file of the presence light controller.
module plc_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [plc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [plc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output plc_pkg::cfg_t                    cfg
);
  import plc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.op_mode     <= OP_MODE_RESET;
      cfg.hold_ms     <= HOLD_MS_RESET;
      cfg.override_ms <= OVERRIDE_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_OP_MODE:     cfg.op_mode     <= cfg_wdata[MODE_W-1:0];
        CFG_HOLD_MS:     cfg.hold_ms     <= cfg_wdata[MS_W-1:0];
        CFG_OVERRIDE_MS: cfg.override_ms <= cfg_wdata[MS_W-1:0];
        default: begin
          // Writes beyond the register list are ignored.
        end
      endcase
    end
  end

endmodule

### rtl/plc_engine.sv
// Lamp state registers and the per-event update logic.
module plc_engine (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  plc_pkg::item_t   item,
  input  plc_pkg::cfg_t    cfg,
  output plc_pkg::result_t result
);
  import plc_pkg::*;

  logic              light_state, light_state_next;
  logic              alarm_hold, alarm_hold_next;
  logic              manual_hold, manual_hold_next;
  logic              override_active, override_active_next;
  logic [TIME_W-1:0] override_until, override_until_next;
  logic [TIME_W-1:0] last_presence_ms, last_presence_ms_next;
  logic              alarm_armed, alarm_armed_next;

  logic              presence;
  logic              power_save;
  logic [TIME_W-1:0] override_age;
  logic [TIME_W-1:0] presence_age;

  assign presence   = (item.radar_state != '0);
  assign power_save = (cfg.op_mode == MODE_POWER_SAVE);

  always_comb begin
    light_state_next      = light_state;
    alarm_hold_next       = alarm_hold;
    manual_hold_next      = manual_hold;
    override_active_next  = override_active;
    override_until_next   = override_until;
    last_presence_ms_next = last_presence_ms;
    alarm_armed_next      = alarm_armed;
    override_age          = '0;
    presence_age          = '0;
    result.lamp_on        = 1'b0;
    result.link_enable    = !power_save;

    unique case (item.req_type)
      REQ_MANUAL_ON: begin
        light_state_next      = 1'b1;
        last_presence_ms_next = item.now_ms;
        alarm_hold_next       = 1'b0;
        manual_hold_next      = 1'b1;
        override_active_next  = 1'b0;
      end
      REQ_MANUAL_OFF: begin
        light_state_next     = 1'b0;
        alarm_hold_next      = 1'b0;
        manual_hold_next     = 1'b0;
        override_active_next = 1'b1;
        override_until_next  = item.now_ms + {{(TIME_W-MS_W){1'b0}}, cfg.override_ms};
      end
      REQ_ARM: begin
        alarm_armed_next = 1'b1;
      end
      REQ_PROCESS: begin
        // An armed alarm on a matching event toggles the lamp and disarms itself.
        if (alarm_armed && item.alarm_match) begin
          if (light_state) begin
            light_state_next = 1'b0;
            alarm_hold_next  = 1'b0;
          end else begin
            light_state_next      = 1'b1;
            alarm_hold_next       = 1'b1;
            last_presence_ms_next = item.now_ms;
          end
          manual_hold_next     = 1'b0;
          override_active_next = 1'b0;
          override_until_next  = '0;
          alarm_armed_next     = 1'b0;
        end
        // The override has run out once the timestamp is at or past its end.
        override_age = item.now_ms - override_until_next;
        if (override_active_next && !override_age[TIME_W-1]) begin
          override_active_next = 1'b0;
        end
        if (!override_active_next && presence && !power_save) begin
          light_state_next      = 1'b1;
          last_presence_ms_next = item.now_ms;
        end
        result.lamp_on = light_state_next;
        // Auto-off of an unheld lamp once presence has been absent long enough.
        presence_age = item.now_ms - last_presence_ms_next;
        if (light_state_next && !manual_hold_next && !alarm_hold_next && !presence &&
            (presence_age >= {{(TIME_W-MS_W){1'b0}}, cfg.hold_ms})) begin
          light_state_next = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      light_state      <= 1'b0;
      alarm_hold       <= 1'b0;
      manual_hold      <= 1'b0;
      override_active  <= 1'b0;
      override_until   <= '0;
      last_presence_ms <= '0;
      alarm_armed      <= 1'b0;
    end else if (fire) begin
      light_state      <= light_state_next;
      alarm_hold       <= alarm_hold_next;
      manual_hold      <= manual_hold_next;
      override_active  <= override_active_next;
      override_until   <= override_until_next;
      last_presence_ms <= last_presence_ms_next;
      alarm_armed      <= alarm_armed_next;
    end
  end

  // A held lamp is always lit.
  a_alarm_hold_lit: assert property (@(posedge clk) disable iff (rst)
    alarm_hold |-> light_state) else $error("alarm hold with lamp off");
  a_manual_hold_lit: assert property (@(posedge clk) disable iff (rst)
    manual_hold |-> light_state) else $error("manual hold with lamp off");
  // The two kinds of hold exclude each other.
  a_single_hold: assert property (@(posedge clk) disable iff (rst)
    !(alarm_hold && manual_hold)) else $error("both holds set");

endmodule

### rtl/presence_light_controller.sv
// Top level of the presence light controller: input stage, engine and result register.
//
// The block takes timestamped lamp events on the input channel (in_valid/in_ready)
// and returns one result transaction (lamp_on, link_enable) on the output channel
// (out_valid/out_ready) for each process pass. Manual on, manual off and arm
// transactions update the lamp state and produce no result.
//
// An accepted transaction lands in an input register. Unless a stalled output
// holds a process pass there, the engine then applies it to the lamp state and,
// for a process pass, loads the result register, which offers the result to the
// receiver. One transaction can be accepted every cycle while the output is not
// stalled, a rate set by the single-pass update of the state registers.
//
// When the receiver stalls with a result waiting, a further process pass is held
// in the input register and in_ready drops once that register is occupied; events
// without a result still drain past the stalled output. Configuration writes via
// cfg_we/cfg_addr/cfg_wdata take effect at once and are meant for an idle block.
// Synchronous reset clears the lamp state and both channels and reloads the
// configuration defaults (normal mode, 5000 ms hold, 30000 ms override).
module presence_light_controller (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [plc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [plc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [plc_pkg::REQ_W-1:0]        req_type,
  input  logic [plc_pkg::TIME_W-1:0]       now_ms,
  input  logic [plc_pkg::RADAR_W-1:0]      radar_state,
  input  logic                             alarm_match,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             lamp_on,
  output logic                             link_enable
);
  import plc_pkg::*;

  cfg_t    cfg;
  item_t   stage_item;
  logic    stage_valid;
  logic    out_free;
  logic    advance;
  logic    has_result;
  result_t engine_result;

  plc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The output slot can take a new result when empty or when it is being drained.
  assign out_free   = !out_valid || out_ready;
  assign has_result = (stage_item.req_type == REQ_PROCESS);
  // A staged transaction leaves when it has nowhere to be blocked.
  assign advance    = stage_valid && (!has_result || out_free);
  assign in_ready   = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item.req_type    <= req_type;
      stage_item.now_ms      <= now_ms;
      stage_item.radar_state <= radar_state;
      stage_item.alarm_match <= alarm_match;
    end
  end

  plc_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (stage_item),
    .cfg    (cfg),
    .result (engine_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      lamp_on     <= engine_result.lamp_on;
      link_enable <= engine_result.link_enable;
    end
  end

  // Only a process pass waiting on a stalled output may sit in the input stage.
  a_stage_block: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !advance) |-> (has_result && out_valid && !out_ready))
    else $error("input stage blocked without cause");
  // A new result appears only after a process pass left the input stage.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(advance && has_result))
    else $error("result without a process pass");
  // A result never overwrites one that the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(advance && has_result))
    else $error("pending result overwritten");

endmodule
